// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is applied
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/h264rtp_pkg.sv
// types, constants and register codes of the h264 rtp packetizer
package h264rtp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int HDR_BYTES       = 12;
    localparam int STEP_BITS       = 4;

    localparam logic [10:0] MAX_PAYLOAD_RST  = 11'd1400;
    localparam logic [10:0] MIN_PAYLOAD      = 11'd5;
    localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
    localparam logic [31:0] SYNC_SOURCE_RST  = 32'h1234_5678;
    localparam logic [31:0] TIME_STEP_RST    = 32'(90000 / 30);

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [4:0] FU_A_TYPE        = 5'd28;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAYLOAD_TYPE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYNC_SOURCE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_STEP    = 3'd3;

    // byte positions inside one packet command
    localparam logic [STEP_BITS-1:0] STEP_HDR_FIRST = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_HDR_LAST  = 4'd11;
    localparam logic [STEP_BITS-1:0] STEP_FU_IND    = 4'd12;
    localparam logic [STEP_BITS-1:0] STEP_FU_HDR    = 4'd13;
    localparam logic [STEP_BITS-1:0] STEP_DATA      = 4'd14;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        nal_first;
        logic        nal_last;
        logic [15:0] nal_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       pkt_end;
        logic       run_end;
    } t_out_beat;

    typedef struct packed {
        logic [10:0] max_payload;
        logic [6:0]  payload_type;
        logic [31:0] sync_source;
        logic [31:0] time_step;
    } t_cfg;

    // one clean byte with the framing that goes in front of it
    typedef struct packed {
        logic        hdr;
        logic        mark;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic        fu;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        pkt_end;
        logic        run_end;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// File: src/h264rtp_front.sv
// front end: start code stripping, packet and fragment decisions, command build
module h264rtp_front #(
    parameter int LENGTH_BITS = h264rtp_pkg::LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  h264rtp_pkg::t_cfg     i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  h264rtp_pkg::t_in_beat i_in_data,
    input  h264rtp_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output h264rtp_pkg::t_cmd     o_cmd
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MAX = '1;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [2:0] STRIP_SHORT = 3'd3;
    localparam logic [2:0] STRIP_LONG  = 3'd4;

    logic [1:0]    r_phase, n_phase;
    logic [LB-1:0] r_byte_index, r_ulen, r_clen, r_clean_pos;
    logic [10:0]   r_foff, r_fsize;
    logic          r_frag;
    logic [7:0]    r_uheader;
    logic [15:0]   r_seq;
    logic [31:0]   r_stamp;
    logic [7:0]    r_lead [4];
    logic          r_flush;
    logic [1:0]    r_flush_k, r_flush_end;

    logic          accept, first;
    logic [24:0]   len_wide;
    logic [LB-1:0] len_sat;
    logic [1:0]    cur_phase;
    logic [LB-1:0] cur_ulen, cur_idx, cur_cpos, cur_clen;
    logic [10:0]   cur_foff;
    logic          cur_frag;
    logic [LB:0]   idx_p1;
    logic          final_b, active, abandon, go, in_lead, in_body;
    logic [7:0]    b;
    logic [1:0]    idx2;
    logic          s_ok;
    logic [2:0]    s_val;
    logic          decide, lead_feed, more, feed_en, run_last;
    logic [LB-1:0] new_cl, cl;
    logic [7:0]    fb;

    // feed stage
    logic          ci_first, f_frag, vcl, f_last, last_frag, emit, frag_end;
    logic [10:0]   m, f_size, f_off, off_inc, n_foff;
    logic [7:0]    f_hdr;
    logic [4:0]    ntype;
    logic [LB:0]   ci_p1, pf_sum;
    logic [LB-1:0] p, total;
    h264rtp_pkg::t_cmd cmd;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = i_q_status.full || r_flush;
    assign first      = accept && i_in_data.nal_first;
    assign b          = i_in_data.nal_byte;

    assign len_wide = 25'(i_in_data.nal_length);
    assign len_sat  = (len_wide > 25'(LEN_MAX)) ? LEN_MAX : len_wide[LB-1:0];

    // a new unit clears the per-unit state in the same beat
    assign cur_phase = first ? ((len_sat == '0) ? PH_IDLE : PH_LEAD) : r_phase;
    assign cur_ulen  = first ? len_sat : r_ulen;
    assign cur_idx   = first ? '0 : r_byte_index;
    assign cur_cpos  = first ? '0 : r_clean_pos;
    assign cur_clen  = first ? '0 : r_clen;
    assign cur_foff  = first ? '0 : r_foff;
    assign cur_frag  = first ? 1'b0 : r_frag;

    assign idx_p1  = {1'b0, cur_idx} + (LB+1)'(1);
    assign final_b = idx_p1 >= {1'b0, cur_ulen};
    assign active  = accept && (cur_phase != PH_IDLE);
    assign abandon = active && i_in_data.nal_last && !final_b;
    assign go      = active && !abandon;
    assign in_lead = go && (cur_phase == PH_LEAD);
    assign in_body = go && (cur_phase == PH_BODY);
    assign idx2    = cur_idx[1:0];

    // start code decision on the leading bytes
    always_comb begin
        s_ok  = 1'b0;
        s_val = '0;
        if (cur_idx == LB'(0) || cur_idx == LB'(1)) begin
            if (b != 8'd0) s_ok = 1'b1;
        end else if (cur_idx == LB'(2)) begin
            if (b == 8'd1) begin
                s_ok  = 1'b1;
                s_val = (cur_ulen > LB'(3)) ? STRIP_SHORT : 3'd0;
            end else if (b != 8'd0) begin
                s_ok = 1'b1;
            end
        end else begin
            s_ok  = 1'b1;
            s_val = (b == 8'd1 && cur_ulen > LB'(4)) ? STRIP_LONG : 3'd0;
        end
        if (!s_ok && final_b) s_ok = 1'b1;
    end

    assign decide    = in_lead && s_ok;
    assign new_cl    = cur_ulen - LB'(s_val);
    assign lead_feed = decide && (s_val <= {1'b0, idx2});
    assign more      = lead_feed && (s_val[1:0] != idx2);

    assign feed_en  = r_flush ? !i_q_status.full : (in_body || lead_feed);
    assign cl       = decide ? new_cl : r_clen;
    assign run_last = r_flush ? (r_flush_k == r_flush_end) : !more;

    always_comb begin
        if (r_flush)      fb = r_lead[r_flush_k];
        else if (more)    fb = r_lead[s_val[1:0]];
        else              fb = b;
    end

    // one clean byte: packet framing and fragment bookkeeping
    assign ci_first = (cur_cpos == '0);
    assign m        = (i_cfg.max_payload < h264rtp_pkg::MIN_PAYLOAD) ?
                      h264rtp_pkg::MIN_PAYLOAD : i_cfg.max_payload;
    assign f_hdr    = ci_first ? fb : r_uheader;
    assign f_frag   = ci_first ? (cl > LB'(m)) : cur_frag;
    assign f_size   = ci_first ? (m - 11'd2) : r_fsize;
    assign f_off    = ci_first ? 11'd0 : cur_foff;
    assign ntype    = f_hdr[4:0];
    assign vcl      = (ntype >= 5'd1) && (ntype <= 5'd5);
    assign ci_p1    = {1'b0, cur_cpos} + (LB+1)'(1);
    assign f_last   = ci_p1 >= {1'b0, cl};
    assign p        = cur_cpos - LB'(1);
    assign total    = cl - LB'(1);
    assign pf_sum   = {1'b0, p} + (LB+1)'(f_size);
    assign last_frag = pf_sum >= {1'b0, total};
    assign off_inc  = f_off + 11'd1;
    assign frag_end = f_last || (off_inc >= f_size);

    always_comb begin
        cmd         = '0;
        cmd.seq     = r_seq;
        cmd.stamp   = r_stamp;
        cmd.data    = fb;
        cmd.run_end = run_last;
        emit        = 1'b0;
        n_foff      = f_off;
        if (!f_frag) begin
            emit        = 1'b1;
            cmd.hdr     = ci_first;
            cmd.mark    = vcl;
            cmd.pkt_end = f_last;
        end else if (!ci_first) begin
            emit = 1'b1;
            if (f_off == 11'd0) begin
                cmd.hdr    = 1'b1;
                cmd.mark   = last_frag && vcl;
                cmd.fu     = 1'b1;
                cmd.fu_ind = {f_hdr[7:5], h264rtp_pkg::FU_A_TYPE};
                cmd.fu_hdr = {(p == '0), (p != '0) && last_frag, 1'b0, ntype};
            end
            cmd.pkt_end = frag_end;
            n_foff      = frag_end ? 11'd0 : off_inc;
        end
    end

    assign o_push = feed_en && emit;
    assign o_cmd  = cmd;

    always_comb begin
        n_phase = cur_phase;
        if (abandon) n_phase = PH_IDLE;
        else if (decide) n_phase = PH_BODY;
        if (feed_en && f_last) n_phase = PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_index <= '0;
            r_ulen       <= '0;
            r_clen       <= '0;
            r_clean_pos  <= '0;
            r_foff       <= '0;
            r_fsize      <= '0;
            r_frag       <= 1'b0;
            r_uheader    <= '0;
            r_seq        <= '0;
            r_stamp      <= '0;
            r_flush      <= 1'b0;
            r_flush_k    <= '0;
            r_flush_end  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_ulen       <= cur_ulen;
            r_byte_index <= go ? idx_p1[LB-1:0] : cur_idx;
            r_clen       <= decide ? new_cl : cur_clen;
            if (feed_en) begin
                r_clean_pos <= ci_p1[LB-1:0];
                r_uheader   <= f_hdr;
                r_frag      <= f_frag;
                r_fsize     <= f_size;
                r_foff      <= n_foff;
                if (emit && cmd.hdr) r_seq <= r_seq + 16'd1;
                if (f_last && vcl)   r_stamp <= r_stamp + i_cfg.time_step;
            end else begin
                r_clean_pos <= cur_cpos;
                r_foff      <= cur_foff;
                r_frag      <= cur_frag;
            end
            // held lead bytes go out one per cycle while the queue is not full, after the decision
            if (more) begin
                r_flush     <= 1'b1;
                r_flush_k   <= s_val[1:0] + 2'd1;
                r_flush_end <= idx2;
            end else if (r_flush && feed_en) begin
                if (r_flush_k == r_flush_end) r_flush <= 1'b0;
                else r_flush_k <= r_flush_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_lead) r_lead[idx2] <= b;
    end

endmodule

// File: src/h264rtp_fifo.sv
// short command queue between front and back
module h264rtp_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  h264rtp_pkg::t_cmd      i_cmd,
    input  logic                   i_pop,
    output h264rtp_pkg::t_q_status o_status,
    output h264rtp_pkg::t_cmd      o_head
);

    localparam int D  = h264rtp_pkg::QUEUE_DEPTH;
    localparam int PB = h264rtp_pkg::QPTR_BITS;

    h264rtp_pkg::t_cmd r_mem [D];
    logic [PB-1:0] r_wr, r_rd;
    logic [PB:0]   r_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (PB+1)'(D));
    assign o_head         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PB'(D - 1)) ? '0 : r_wr + PB'(1);
            if (i_pop)  r_rd <= (r_rd == PB'(D - 1)) ? '0 : r_rd + PB'(1);
            if (i_push && !i_pop)      r_count <= r_count + (PB+1)'(1);
            else if (i_pop && !i_push) r_count <= r_count - (PB+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

// File: src/h264rtp_back.sv
// back end: expands commands into rtp header, fu bytes and payload bytes
module h264rtp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  h264rtp_pkg::t_cfg       i_cfg,
    input  h264rtp_pkg::t_q_status  i_q_status,
    input  h264rtp_pkg::t_cmd       i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output h264rtp_pkg::t_out_beat  o_out_data
);

    localparam int SB = h264rtp_pkg::STEP_BITS;

    logic          r_busy;
    logic [SB-1:0] r_step;
    logic          r_out_valid;
    h264rtp_pkg::t_out_beat r_out;

    logic          load;
    logic [SB-1:0] start, eff, next;
    logic [7:0]    hdr_bytes [h264rtp_pkg::HDR_BYTES];
    h264rtp_pkg::t_out_beat beat;

    assign load  = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign start = i_head.hdr ? h264rtp_pkg::STEP_HDR_FIRST :
                   (i_head.fu ? h264rtp_pkg::STEP_FU_IND : h264rtp_pkg::STEP_DATA);
    assign eff   = r_busy ? r_step : start;
    assign o_pop = load && (eff == h264rtp_pkg::STEP_DATA);

    always_comb begin
        hdr_bytes[0]  = h264rtp_pkg::RTP_VERSION_BYTE;
        hdr_bytes[1]  = {i_head.mark, i_cfg.payload_type};
        hdr_bytes[2]  = i_head.seq[15:8];
        hdr_bytes[3]  = i_head.seq[7:0];
        hdr_bytes[4]  = i_head.stamp[31:24];
        hdr_bytes[5]  = i_head.stamp[23:16];
        hdr_bytes[6]  = i_head.stamp[15:8];
        hdr_bytes[7]  = i_head.stamp[7:0];
        hdr_bytes[8]  = i_cfg.sync_source[31:24];
        hdr_bytes[9]  = i_cfg.sync_source[23:16];
        hdr_bytes[10] = i_cfg.sync_source[15:8];
        hdr_bytes[11] = i_cfg.sync_source[7:0];
    end

    always_comb begin
        beat = '0;
        priority if (eff <= h264rtp_pkg::STEP_HDR_LAST) begin
            beat.pkt_byte = hdr_bytes[eff];
        end else if (eff == h264rtp_pkg::STEP_FU_IND) begin
            beat.pkt_byte = i_head.fu_ind;
        end else if (eff == h264rtp_pkg::STEP_FU_HDR) begin
            beat.pkt_byte = i_head.fu_hdr;
        end else begin
            beat.pkt_byte = i_head.data;
            beat.pkt_end  = i_head.pkt_end;
            beat.run_end  = i_head.run_end;
        end
    end

    // after the last header byte jump to the fu bytes or the payload byte
    assign next = (eff == h264rtp_pkg::STEP_HDR_LAST) ?
                  (i_head.fu ? h264rtp_pkg::STEP_FU_IND : h264rtp_pkg::STEP_DATA) :
                  eff + SB'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (eff == h264rtp_pkg::STEP_DATA) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= next;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/h264_rtp_packetizer_unit.sv
// a payload byte is registered in the command queue and then in the output register
// each packet adds 12 rtp header bytes, each fu-a fragment 2 more, one per cycle while the output is not stalled
// body throughput is one byte per cycle while the output is not stalled, set by the single output byte port
// a flushed start code window holds the input while the held lead bytes go out
// synchronous active-low reset clears the control state and loads the default registers
module h264_rtp_packetizer_unit #(
    parameter int LENGTH_BITS = h264rtp_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  h264rtp_pkg::t_in_beat  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output h264rtp_pkg::t_out_beat o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [h264rtp_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    h264rtp_pkg::t_cfg      r_cfg;
    h264rtp_pkg::t_q_status q_status;
    h264rtp_pkg::t_cmd      push_cmd, head_cmd;
    logic                   push, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload  <= h264rtp_pkg::MAX_PAYLOAD_RST;
            r_cfg.payload_type <= h264rtp_pkg::PAYLOAD_TYPE_RST;
            r_cfg.sync_source  <= h264rtp_pkg::SYNC_SOURCE_RST;
            r_cfg.time_step    <= h264rtp_pkg::TIME_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                h264rtp_pkg::CFG_MAX_PAYLOAD:  r_cfg.max_payload  <= i_cfg_data[10:0];
                h264rtp_pkg::CFG_PAYLOAD_TYPE: r_cfg.payload_type <= i_cfg_data[6:0];
                h264rtp_pkg::CFG_SYNC_SOURCE:  r_cfg.sync_source  <= i_cfg_data;
                h264rtp_pkg::CFG_TIME_STEP:    r_cfg.time_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    h264rtp_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    h264rtp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head_cmd)
    );

    h264rtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: src/h264rtp_checker.sv
// port-level checks of the packetizer, bound to the top level
`include "assert_macros.svh"

module h264rtp_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input h264rtp_pkg::t_out_beat o_out_data
);

    logic r_after_end;

    // set after a beat that closed a packet, until the next beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b1;
        end else if (o_out_valid && !i_out_stall) begin
            r_after_end <= o_out_data.pkt_end;
        end
    end

    `CHK_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled output beat changed")
    `CHK_ASSERT(a_pkt_start, o_out_valid && r_after_end |-> o_out_data.pkt_byte == h264rtp_pkg::RTP_VERSION_BYTE, "packet does not open with the version byte")
    `CHK_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `CHK_ASSERT_ALWAYS(a_rst_in, !i_rst_n |=> !o_in_stall, "input stalled after reset")

endmodule

bind h264_rtp_packetizer_unit h264rtp_checker u_h264rtp_checker (.*);

// File: sim/tb_h264_rtp_packetizer_unit.sv
// testbench for the h264 rtp packetizer: directed rows, then random nal units checked by a predictor
`timescale 1ns / 1ps

module tb_h264_rtp_packetizer_unit;
    import h264rtp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 100;
    localparam logic signed [7:0] BY_MODEL = -8'sd1;

    typedef enum logic [1:0] {UNIT_IDLE, UNIT_LEAD, UNIT_BODY} t_unit_phase;
    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [CFG_INDEX_BITS-1:0]   reg_idx;
        logic [31:0]                 reg_val;
        t_in_beat                    beat;
        logic signed [7:0]           n_typed;   // packet bytes caused, or BY_MODEL
    } t_row;

    // directed rows: byte, first, last, length
    localparam t_row PLAN [0:32] = '{
        // single byte idr unit straight after reset
        '{ROW_BEAT, '0, 32'd0, '{8'h65, 1'b1, 1'b1, 16'd1},      8'sd13},
        // empty unit
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b1, 1'b0, 16'd0},      8'sd0},
        // late nal_last while idle
        '{ROW_BEAT, '0, 32'd0, '{8'h3C, 1'b0, 1'b1, 16'hFFFF},   8'sd0},
        // four byte start code stripped
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b1, 1'b0, 16'd6},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h01, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h41, 1'b0, 1'b0, 16'd0},      8'sd13},
        '{ROW_BEAT, '0, 32'd0, '{8'h9A, 1'b0, 1'b1, 16'd0},      8'sd1},
        // four byte start code kept when the unit is only 4 bytes
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b1, 1'b0, 16'd4},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h01, 1'b0, 1'b1, 16'd0},      8'sd16},
        // three byte start code kept when the unit is only 3 bytes
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b1, 1'b0, 16'd3},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h01, 1'b0, 1'b1, 16'd0},      8'sd15},
        // three byte start code stripped
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b1, 1'b0, 16'd4},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h00, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h01, 1'b0, 1'b0, 16'd0},      8'sd0},
        '{ROW_BEAT, '0, 32'd0, '{8'h67, 1'b0, 1'b1, 16'd0},      8'sd13},
        // early nal_last abandons the unit
        '{ROW_BEAT, '0, 32'd0, '{8'h41, 1'b1, 1'b0, 16'd3},      8'sd13},
        '{ROW_BEAT, '0, 32'd0, '{8'h77, 1'b0, 1'b1, 16'd0},      8'sd0},
        // longest unit, abandoned by the next first byte
        '{ROW_BEAT, '0, 32'd0, '{8'hFF, 1'b1, 1'b0, 16'hFFFF},   8'sd0},
        '{ROW_CFG, CFG_MAX_PAYLOAD,  32'd3,         '0,           BY_MODEL},
        '{ROW_CFG, CFG_PAYLOAD_TYPE, 32'd127,       '0,           BY_MODEL},
        '{ROW_CFG, CFG_SYNC_SOURCE,  32'hFFFF_FFFF, '0,           BY_MODEL},
        '{ROW_CFG, CFG_TIME_STEP,    32'hFFFF_FFFF, '0,           BY_MODEL},
        // fu-a split with the smallest fragments
        '{ROW_BEAT, '0, 32'd0, '{8'h65, 1'b1, 1'b0, 16'd6},      BY_MODEL},
        '{ROW_BEAT, '0, 32'd0, '{8'h11, 1'b0, 1'b0, 16'd0},      BY_MODEL},
        '{ROW_BEAT, '0, 32'd0, '{8'h22, 1'b0, 1'b0, 16'd0},      BY_MODEL},
        '{ROW_BEAT, '0, 32'd0, '{8'h33, 1'b0, 1'b0, 16'd0},      BY_MODEL},
        '{ROW_BEAT, '0, 32'd0, '{8'h44, 1'b0, 1'b0, 16'd0},      BY_MODEL},
        '{ROW_BEAT, '0, 32'd0, '{8'h55, 1'b0, 1'b1, 16'd0},      BY_MODEL}
    };

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_beat                  i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_beat                 o_out_data;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [31:0]               i_cfg_data  = '0;

    h264_rtp_packetizer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // packetizer state as the predictor sees it
    t_cfg        cfg_model = '{MAX_PAYLOAD_RST, PAYLOAD_TYPE_RST, SYNC_SOURCE_RST, TIME_STEP_RST};
    logic [15:0] seq_no    = '0;
    logic [31:0] stamp     = '0;
    logic [7:0]  lead [4];
    logic [7:0]  nal_hdr   = '0;
    t_unit_phase unit_phase = UNIT_IDLE;
    logic        split     = 1'b0;
    int          byte_pos  = 0;
    int          unit_len  = 0;
    int          clean_len = 0;
    int          clean_idx = 0;
    int          frag_cnt  = 0;
    int          chunk     = 0;

    t_out_beat   step_out[$];
    t_out_beat   rtp_bytes_due[$];
    int          error_count = 0;
    bit          calm        = 1'b0;
    bit          hold_go     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("h264_rtp_packetizer_unit test failed");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b, input logic e);
        t_out_beat o;
        o.pkt_byte = b;
        o.pkt_end  = e;
        o.run_end  = 1'b0;
        step_out.push_back(o);
    endtask

    task automatic put_rtp_header(input logic mark);
        put_byte(RTP_VERSION_BYTE, 1'b0);
        put_byte({mark, cfg_model.payload_type}, 1'b0);
        put_byte(seq_no[15:8], 1'b0);
        put_byte(seq_no[7:0], 1'b0);
        put_byte(stamp[31:24], 1'b0);
        put_byte(stamp[23:16], 1'b0);
        put_byte(stamp[15:8], 1'b0);
        put_byte(stamp[7:0], 1'b0);
        put_byte(cfg_model.sync_source[31:24], 1'b0);
        put_byte(cfg_model.sync_source[23:16], 1'b0);
        put_byte(cfg_model.sync_source[15:8], 1'b0);
        put_byte(cfg_model.sync_source[7:0], 1'b0);
        seq_no = seq_no + 16'd1;
    endtask

    // one byte of the unit after start code removal
    task automatic pack_clean(input logic [7:0] b);
        int          m, p, total;
        logic        last, vcl, last_frag, e;
        logic [4:0]  nt;
        last = (clean_idx + 1 >= clean_len);
        if (clean_idx == 0) begin
            m = cfg_model.max_payload;
            if (m < MIN_PAYLOAD)
                m = MIN_PAYLOAD;
            nal_hdr  = b;
            split    = (clean_len > m);
            chunk    = m - 2;
            frag_cnt = 0;
        end
        nt  = nal_hdr[4:0];
        vcl = (nt >= 5'd1 && nt <= 5'd5);
        if (!split) begin
            if (clean_idx == 0)
                put_rtp_header(vcl);
            put_byte(b, last);
        end else if (clean_idx != 0) begin
            p     = clean_idx - 1;
            total = clean_len - 1;
            if (frag_cnt == 0) begin
                last_frag = (p + chunk >= total);
                put_rtp_header(last_frag && vcl);
                put_byte({nal_hdr[7:5], FU_A_TYPE}, 1'b0);
                put_byte({p == 0, p != 0 && last_frag, 1'b0, nt}, 1'b0);
            end
            frag_cnt++;
            e = last || frag_cnt >= chunk;
            put_byte(b, e);
            if (e)
                frag_cnt = 0;
        end
        clean_idx++;
        if (last) begin
            if (vcl)
                stamp = stamp + cfg_model.time_step;
            unit_phase = UNIT_IDLE;
        end
    endtask

    // expected packet bytes for one accepted input beat
    task automatic packetize_beat(input t_in_beat bt, output int n);
        int   idx, s, k;
        logic fin;
        step_out.delete();
        if (bt.nal_first) begin
            unit_len   = bt.nal_length;
            byte_pos   = 0;
            clean_idx  = 0;
            frag_cnt   = 0;
            clean_len  = 0;
            split      = 1'b0;
            unit_phase = (unit_len == 0) ? UNIT_IDLE : UNIT_LEAD;
        end
        if (unit_phase != UNIT_IDLE) begin
            idx = byte_pos;
            fin = (idx + 1 >= unit_len);
            if (bt.nal_last && !fin) begin
                unit_phase = UNIT_IDLE;
            end else begin
                if (unit_phase == UNIT_LEAD) begin
                    // hold up to four bytes until the start code is decided
                    lead[idx[1:0]] = bt.nal_byte;
                    s = -1;
                    if (idx <= 1) begin
                        if (bt.nal_byte != 8'h00)
                            s = 0;
                    end else if (idx == 2) begin
                        if (bt.nal_byte == 8'h01)
                            s = (unit_len > 3) ? 3 : 0;
                        else if (bt.nal_byte != 8'h00)
                            s = 0;
                    end else begin
                        s = (bt.nal_byte == 8'h01 && unit_len > 4) ? 4 : 0;
                    end
                    if (s < 0 && fin)
                        s = 0;
                    if (s >= 0) begin
                        clean_len  = unit_len - s;
                        unit_phase = UNIT_BODY;
                        for (k = s; k <= idx && k < 4; k++)
                            pack_clean(lead[k]);
                    end
                end else begin
                    pack_clean(bt.nal_byte);
                end
                byte_pos = (idx + 1) & 32'hFFFF;
            end
        end
        n = step_out.size();
        if (n > 0)
            step_out[n - 1].run_end = 1'b1;
        foreach (step_out[i])
            rtp_bytes_due.push_back(step_out[i]);
    endtask

    task automatic send_beat(input t_in_beat bt, output int n);
        if (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= bt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        packetize_beat(bt, n);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_PAYLOAD:  cfg_model.max_payload  = val[10:0];
            CFG_PAYLOAD_TYPE: cfg_model.payload_type = val[6:0];
            CFG_SYNC_SOURCE:  cfg_model.sync_source  = val;
            CFG_TIME_STEP:    cfg_model.time_step    = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until every packet byte is out and the start code window has drained
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (rtp_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic make_unit(ref t_in_beat beats[$], output bit noise);
        int         kind, pre, body_len, n, cut, r;
        logic [7:0] bytes[$];
        logic [7:0] hdr;
        t_in_beat   bt;
        beats.delete();
        noise = 1'b0;
        kind  = $urandom_range(0, 99);
        if (kind >= 97) begin
            // stray bytes outside any unit
            noise = 1'b1;
            repeat ($urandom_range(1, 3)) begin
                bt = t_in_beat'($urandom);
                bt.nal_first = 1'b0;
                beats.push_back(bt);
            end
            return;
        end
        if (kind >= 94) begin
            bt = t_in_beat'($urandom);
            bt.nal_first  = 1'b1;
            bt.nal_length = '0;
            beats.push_back(bt);
            return;
        end
        pre = $urandom_range(0, 5);
        case (pre)
            1: bytes = '{8'h00, 8'h00, 8'h01};
            2: bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
            3: bytes = '{8'h00, 8'h00, 8'h00, 8'($urandom)};
            4: bytes = '{8'h00, 8'($urandom)};
            5: bytes = '{8'h00, 8'h00, 8'($urandom)};
            default: bytes.delete();
        endcase
        r = $urandom_range(0, 99);
        if (r < 80)
            body_len = $urandom_range(pre == 0 ? 1 : 0, 12);
        else if (r < 95)
            body_len = $urandom_range(13, 60);
        else
            body_len = $urandom_range(61, 200);
        hdr = 8'($urandom);
        if ($urandom_range(0, 1))
            hdr[4:0] = 5'($urandom_range(1, 5));
        for (int i = 0; i < body_len; i++)
            bytes.push_back(i == 0 ? hdr :
                            ($urandom_range(0, 7) == 0 ? 8'h00 : 8'($urandom)));
        n = bytes.size();
        for (int i = 0; i < n; i++) begin
            bt.nal_byte   = bytes[i];
            bt.nal_first  = (i == 0);
            bt.nal_last   = (i == n - 1);
            bt.nal_length = (i == 0) ? 16'(n) : 16'($urandom);
            beats.push_back(bt);
        end
        if (kind >= 88 && n > 1) begin
            // nal_last arrives before the announced length
            cut = $urandom_range(0, n - 2);
            beats[cut].nal_last = 1'b1;
            while (beats.size() > cut + 1) void'(beats.pop_back());
        end else if (kind >= 80 && n > 1) begin
            // cut short, the next first byte abandons it
            cut = $urandom_range(1, n - 1);
            while (beats.size() > cut) void'(beats.pop_back());
            if ($urandom_range(0, 1))
                beats[0].nal_length = 16'($urandom_range(n, 65535));
        end
    endtask

    // receiver: random stall, quiet stretch, one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 25);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rtp_bytes_due.size() == 0) begin
                $display("%0t: unexpected beat, got byte %h end %b run_end %b",
                         $time, o_out_data.pkt_byte, o_out_data.pkt_end,
                         o_out_data.run_end);
                error_count++;
            end else begin
                want = rtp_bytes_due.pop_front();
                if (o_out_data.pkt_byte !== want.pkt_byte ||
                    o_out_data.pkt_end  !== want.pkt_end  ||
                    o_out_data.run_end  !== want.run_end) begin
                    $display("%0t: expected byte %h end %b run_end %b, got byte %h end %b run_end %b",
                             $time, want.pkt_byte, want.pkt_end, want.run_end,
                             o_out_data.pkt_byte, o_out_data.pkt_end,
                             o_out_data.run_end);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_in_beat    beats[$];
        bit          noise, held;
        int          n, items;
        logic [10:0] mp;
        logic [6:0]  pt;
        logic [31:0] ssrc, step, val;

        held = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(PLAN); r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                if (r == 0 || PLAN[r - 1].kind != ROW_CFG)
                    settle_block();
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
            end else begin
                send_beat(PLAN[r].beat, n);
                if (PLAN[r].n_typed != BY_MODEL && n != PLAN[r].n_typed) begin
                    $display("%0t: row %0d expected %0d packet bytes, predicted %0d",
                             $time, r, PLAN[r].n_typed, n);
                    error_count++;
                end
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_block();
            case (ph)
                0: begin
                    mp = 11'd3;    pt = 7'd0;   ssrc = '0; step = '1;
                end
                1: begin
                    mp = 11'd1460; pt = 7'd127; ssrc = '1; step = '0;
                end
                default: begin
                    mp   = 11'($urandom_range(4, 40));
                    pt   = 7'($urandom_range(0, 127));
                    ssrc = $urandom;
                    step = $urandom;
                end
            endcase
            // unused upper data bits carry noise
            val = $urandom;
            val[10:0] = mp;
            write_reg(CFG_MAX_PAYLOAD, val);
            val = $urandom;
            val[6:0] = pt;
            write_reg(CFG_PAYLOAD_TYPE, val);
            write_reg(CFG_SYNC_SOURCE, ssrc);
            write_reg(CFG_TIME_STEP, step);
            write_reg(CFG_TIME_STEP + CFG_INDEX_BITS'($urandom_range(1, 4)), $urandom);

            calm  = (ph == 1);
            items = 0;
            while (items < PHASE_ITEMS) begin
                make_unit(beats, noise);
                foreach (beats[i])
                    send_beat(beats[i], n);
                if (!noise)
                    items += beats.size();
                if (ph == 3 && !held && items >= 40) begin
                    held    = 1'b1;
                    hold_go = 1'b1;
                end
            end
            calm = 1'b0;
        end

        settle_block();
        if (error_count == 0) begin
            $display("h264_rtp_packetizer_unit test passed");
        end else begin
            $display("h264_rtp_packetizer_unit test failed");
        end
        $finish;
    end

endmodule
